// File: rtl/core/stc_pkg.sv
// Shared types, constants and helper functions for the servo test command generator.
// No dependencies; every other file in rtl/core imports this package.
package stc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned LIM_W    = 10;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned POT_W    = 8;
  localparam int unsigned CMD_W    = 11;
  localparam int unsigned WIDE_W   = CMD_W + 1;
  localparam int unsigned RATE_W   = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PERIODS  = 4;

  localparam int unsigned RATE_ENTRIES_DEF = 4;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned REG_IDX_W   = 3;

  localparam logic [TIME_W-1:0] START_WINDOW_MS = TIME_W'(100);
  localparam int unsigned       POT_SCALE       = 200;
  localparam int unsigned       POT_OFFSET      = 100;

  localparam logic [MODE_W-1:0] MODE_POT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COARSE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_FINE_STEP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COARSE_STEP = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_COMMAND = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_0    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_1    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_2    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_3    = 3'd6;

  localparam logic [STEP_W-1:0]   FINE_STEP_RST   = 8'd1;
  localparam logic [STEP_W-1:0]   COARSE_STEP_RST = 8'd10;
  localparam logic [LIM_W-1:0]    MAX_COMMAND_RST = 10'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_0_RST    = 10'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_1_RST    = 10'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_2_RST    = 10'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_3_RST    = 10'd3;

  typedef struct packed {
    logic [STEP_W-1:0]                 fine_step;
    logic [STEP_W-1:0]                 coarse_step;
    logic [LIM_W-1:0]                  max_command;
    logic [PERIODS-1:0][PERIOD_W-1:0]  period_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              rate_button;
    logic              mode_button;
    logic [POT_W-1:0]  pot_level;
    logic              callbacks_none;
    logic              update_pending;
    logic              driver_ready;
  } in_item_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] steer_command;
    logic                    command_issued;
    logic [RATE_W-1:0]       rate_index;
    logic [MODE_W-1:0]       motion_mode;
    logic                    no_callback_fault;
    logic                    lag_fault;
    logic                    led_red;
  } res_item_t;

  // Scales the pot byte onto -100..100; the divide by 255 is done with the
  // usual reciprocal trick, exact for every product below 255 * 256.
  function automatic logic signed [WIDE_W-1:0] pot_command(input logic [POT_W-1:0] level);
    logic [15:0] prod;
    logic [15:0] quot;
    prod = 16'(level) * 16'(POT_SCALE);
    quot = (prod + (prod >> 8) + 16'd1) >> 8;
    return $signed(WIDE_W'(quot)) - $signed(WIDE_W'(POT_OFFSET));
  endfunction

endpackage

// File: rtl/core/stc_cfg.sv
// Configuration register file with an APB-style access port.
// Depends on stc_pkg for register indexes, reset values and the cfg_t bundle.
module stc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [stc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output stc_pkg::cfg_t                  cfg
);
  import stc_pkg::*;

  logic [STEP_W-1:0]   fine_step_r;
  logic [STEP_W-1:0]   coarse_step_r;
  logic [LIM_W-1:0]    max_command_r;
  logic [PERIOD_W-1:0] period_0_r;
  logic [PERIOD_W-1:0] period_1_r;
  logic [PERIOD_W-1:0] period_2_r;
  logic [PERIOD_W-1:0] period_3_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_step_r   <= FINE_STEP_RST;
      coarse_step_r <= COARSE_STEP_RST;
      max_command_r <= MAX_COMMAND_RST;
      period_0_r    <= PERIOD_0_RST;
      period_1_r    <= PERIOD_1_RST;
      period_2_r    <= PERIOD_2_RST;
      period_3_r    <= PERIOD_3_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FINE_STEP:   fine_step_r   <= pwdata[STEP_W-1:0];
        REG_COARSE_STEP: coarse_step_r <= pwdata[STEP_W-1:0];
        REG_MAX_COMMAND: max_command_r <= pwdata[LIM_W-1:0];
        REG_PERIOD_0:    period_0_r    <= pwdata[PERIOD_W-1:0];
        REG_PERIOD_1:    period_1_r    <= pwdata[PERIOD_W-1:0];
        REG_PERIOD_2:    period_2_r    <= pwdata[PERIOD_W-1:0];
        REG_PERIOD_3:    period_3_r    <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FINE_STEP:   prdata = CFG_DATA_W'(fine_step_r);
      REG_COARSE_STEP: prdata = CFG_DATA_W'(coarse_step_r);
      REG_MAX_COMMAND: prdata = CFG_DATA_W'(max_command_r);
      REG_PERIOD_0:    prdata = CFG_DATA_W'(period_0_r);
      REG_PERIOD_1:    prdata = CFG_DATA_W'(period_1_r);
      REG_PERIOD_2:    prdata = CFG_DATA_W'(period_2_r);
      REG_PERIOD_3:    prdata = CFG_DATA_W'(period_3_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.fine_step    = fine_step_r;
  assign cfg.coarse_step  = coarse_step_r;
  assign cfg.max_command  = max_command_r;
  assign cfg.period_ms[0] = period_0_r;
  assign cfg.period_ms[1] = period_1_r;
  assign cfg.period_ms[2] = period_2_r;
  assign cfg.period_ms[3] = period_3_r;

endmodule

// File: rtl/core/stc_core.sv
// Per-tick state of the generator and the single-pass logic that updates it.
// Depends on stc_pkg for the item, result and configuration types.
module stc_core #(
  parameter int unsigned RATE_ENTRIES = stc_pkg::RATE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  stc_pkg::in_item_t  item,
  input  stc_pkg::cfg_t      cfg,
  output stc_pkg::res_item_t res
);
  import stc_pkg::*;

  localparam logic [RATE_W-1:0] RATE_LAST = RATE_W'(RATE_ENTRIES - 1);

  logic [RATE_W-1:0]       rate_sel_r,  rate_sel_nxt;
  logic [MODE_W-1:0]       mode_sel_r,  mode_sel_nxt;
  logic signed [CMD_W-1:0] command_r,   command_nxt;
  logic                    sweep_up_r,  sweep_up_nxt;
  logic [TIME_W-1:0]       next_due_r,  next_due_nxt;
  logic [TIME_W-1:0]       start_ms_r,  start_ms_nxt;
  logic                    started_r;
  logic                    cb_fault_r,  cb_fault_nxt;
  logic                    lag_fault_r, lag_fault_nxt;

  logic                     issue;
  logic [TIME_W-1:0]        elapsed;
  logic [TIME_W-1:0]        since_due;
  logic [STEP_W-1:0]        step;
  logic signed [WIDE_W-1:0] cmd_wide;
  logic signed [WIDE_W-1:0] step_wide;
  logic signed [WIDE_W-1:0] raw_cmd;
  logic signed [WIDE_W-1:0] lim_wide;
  logic signed [WIDE_W-1:0] clamped;

  always_comb begin
    start_ms_nxt  = started_r ? start_ms_r : item.now_ms;
    next_due_nxt  = started_r ? next_due_r : item.now_ms;
    rate_sel_nxt  = rate_sel_r;
    mode_sel_nxt  = mode_sel_r;
    command_nxt   = command_r;
    sweep_up_nxt  = sweep_up_r;
    cb_fault_nxt  = cb_fault_r;
    lag_fault_nxt = lag_fault_r;

    if (item.rate_button) begin
      rate_sel_nxt  = (rate_sel_r == RATE_LAST) ? '0 : rate_sel_r + RATE_W'(1);
      next_due_nxt  = item.now_ms;
      cb_fault_nxt  = 1'b0;
      lag_fault_nxt = 1'b0;
    end
    if (item.mode_button) begin
      mode_sel_nxt  = (mode_sel_r == MODE_COARSE) ? MODE_POT : mode_sel_r + MODE_W'(1);
      command_nxt   = '0;
      sweep_up_nxt  = 1'b1;
      next_due_nxt  = item.now_ms;
      cb_fault_nxt  = 1'b0;
      lag_fault_nxt = 1'b0;
    end

    elapsed = item.now_ms - start_ms_nxt;
    if (elapsed > START_WINDOW_MS && item.callbacks_none) begin
      cb_fault_nxt = 1'b1;
    end

    since_due = item.now_ms - next_due_nxt;
    issue     = !since_due[TIME_W-1];

    step      = (mode_sel_nxt == MODE_COARSE) ? cfg.coarse_step : cfg.fine_step;
    cmd_wide  = WIDE_W'(command_nxt);
    step_wide = $signed(WIDE_W'(step));
    if (mode_sel_nxt == MODE_FINE || mode_sel_nxt == MODE_COARSE) begin
      raw_cmd = sweep_up_nxt ? cmd_wide + step_wide : cmd_wide - step_wide;
    end else begin
      raw_cmd = pot_command(item.pot_level);
    end

    lim_wide = $signed(WIDE_W'(cfg.max_command));
    clamped  = raw_cmd;
    if (issue) begin
      lag_fault_nxt = item.update_pending;
      if (raw_cmd >= lim_wide) begin
        clamped      = lim_wide;
        sweep_up_nxt = 1'b0;
      end else if (raw_cmd <= -lim_wide) begin
        clamped      = -lim_wide;
        sweep_up_nxt = 1'b1;
      end
      command_nxt  = clamped[CMD_W-1:0];
      next_due_nxt = item.now_ms + TIME_W'(cfg.period_ms[rate_sel_nxt]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_sel_r  <= '0;
      mode_sel_r  <= MODE_POT;
      command_r   <= '0;
      sweep_up_r  <= 1'b1;
      next_due_r  <= '0;
      start_ms_r  <= '0;
      started_r   <= 1'b0;
      cb_fault_r  <= 1'b0;
      lag_fault_r <= 1'b0;
    end else if (adv) begin
      rate_sel_r  <= rate_sel_nxt;
      mode_sel_r  <= mode_sel_nxt;
      command_r   <= command_nxt;
      sweep_up_r  <= sweep_up_nxt;
      next_due_r  <= next_due_nxt;
      start_ms_r  <= start_ms_nxt;
      started_r   <= 1'b1;
      cb_fault_r  <= cb_fault_nxt;
      lag_fault_r <= lag_fault_nxt;
    end
  end

  assign res.steer_command     = command_nxt;
  assign res.command_issued    = issue;
  assign res.rate_index        = rate_sel_nxt;
  assign res.motion_mode       = mode_sel_nxt;
  assign res.no_callback_fault = cb_fault_nxt;
  assign res.lag_fault         = lag_fault_nxt;
  assign res.led_red           = cb_fault_nxt || !item.driver_ready || lag_fault_nxt;

endmodule

// File: rtl/core/servo_test_command_generator.sv
// Top level of the servo test command generator: input register, result register.
// Depends on stc_pkg, stc_cfg and stc_core.
//
//   Port group   Direction  Handshake              Payload
//   in_*         slave      in_tvalid / in_tready  one update tick (48-bit tdata)
//   out_*        master     out_tvalid / out_tready one result per tick (24-bit tdata)
//   cfg_*        slave      APB write/read         seven configuration registers
//
// An accepted item passes through the input register and then through the update logic
// into the result register. One item is accepted every cycle while the output is not stalled.
// Reset is synchronous and active low; it empties both registers and restores all state.
// A stalled result holds in the result register while one more item waits at the input.
module servo_test_command_generator #(
  parameter int unsigned RATE_ENTRIES = stc_pkg::RATE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // now_ms[31:0], rate_button[32], mode_button[33], pot_level[41:34],
  // callbacks_none[42], update_pending[43], driver_ready[44], zero[47:45]
  input  logic [stc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // steer_command[10:0], command_issued[11], rate_index[13:12], motion_mode[15:14],
  // no_callback_fault[16], lag_fault[17], led_red[18], zero[23:19]
  output logic [stc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [stc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [stc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import stc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  item_r;
  logic      in_valid_r;
  res_item_t core_res;
  res_item_t res_r;
  logic      out_valid_r;
  logic      adv;

  assign in_item.now_ms         = in_tdata[31:0];
  assign in_item.rate_button    = in_tdata[32];
  assign in_item.mode_button    = in_tdata[33];
  assign in_item.pot_level      = in_tdata[41:34];
  assign in_item.callbacks_none = in_tdata[42];
  assign in_item.update_pending = in_tdata[43];
  assign in_item.driver_ready   = in_tdata[44];

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  stc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  stc_core #(
    .RATE_ENTRIES (RATE_ENTRIES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.led_red, res_r.lag_fault, res_r.no_callback_fault,
                       res_r.motion_mode, res_r.rate_index, res_r.command_issued,
                       res_r.steer_command};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input register empty but item refused");

  a_button_issues: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (item_r.rate_button || item_r.mode_button) |-> core_res.command_issued)
    else $error("button press did not issue a command");

  a_clamp_upper: assert property (@(posedge clk) disable iff (!rst_n)
    adv && core_res.command_issued |->
      $signed({core_res.steer_command[CMD_W-1], core_res.steer_command})
        <= $signed({2'b00, cfg.max_command}))
    else $error("issued command above the clamp limit");

  a_clamp_lower: assert property (@(posedge clk) disable iff (!rst_n)
    adv && core_res.command_issued |->
      $signed({core_res.steer_command[CMD_W-1], core_res.steer_command})
        >= -$signed({2'b00, cfg.max_command}))
    else $error("issued command below the clamp limit");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid && res_r == $past(core_res))
    else $error("result register not loaded after an item advanced");
`endif

endmodule

// File: verif/servo_test_command_generator_tb.sv
// Self-checking testbench for servo_test_command_generator: update ticks go in on the
// input stream, status items are checked against a cycle-free model of the block.
// Depends on stc_pkg and the RTL top level, and through it on stc_cfg and stc_core.
module servo_test_command_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  localparam int          MODE_COUNT   = 3;
  localparam int          POT_FULL     = 255;
  localparam int          LONG_HOLD    = 80;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          DRAIN_PAUSE  = 6;
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 75;
  localparam logic [31:0] DIR_START    = 32'hFFFF_FFC0;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  class stc_status_scoreboard;
    logic [STEP_W-1:0]       fine_step;
    logic [STEP_W-1:0]       coarse_step;
    logic [LIM_W-1:0]        max_command;
    logic [PERIOD_W-1:0]     period_ms [PERIODS];
    logic [RATE_W-1:0]       rate_sel;
    logic [MODE_W-1:0]       mode_sel;
    logic signed [CMD_W-1:0] command_value;
    logic                    sweep_up;
    logic                    started;
    logic                    callback_fault;
    logic                    lag_fault;
    logic [TIME_W-1:0]       next_due_ms;
    logic [TIME_W-1:0]       start_ms;
    res_item_t               awaited_status [$];
    int                      failures;

    function new();
      fine_step      = FINE_STEP_RST;
      coarse_step    = COARSE_STEP_RST;
      max_command    = MAX_COMMAND_RST;
      period_ms[0]   = PERIOD_0_RST;
      period_ms[1]   = PERIOD_1_RST;
      period_ms[2]   = PERIOD_2_RST;
      period_ms[3]   = PERIOD_3_RST;
      rate_sel       = '0;
      mode_sel       = MODE_POT;
      command_value  = '0;
      sweep_up       = 1'b1;
      started        = 1'b0;
      callback_fault = 1'b0;
      lag_fault      = 1'b0;
      next_due_ms    = '0;
      start_ms       = '0;
      failures       = 0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_FINE_STEP:   fine_step    = value[STEP_W-1:0];
        REG_COARSE_STEP: coarse_step  = value[STEP_W-1:0];
        REG_MAX_COMMAND: max_command  = value[LIM_W-1:0];
        REG_PERIOD_0:    period_ms[0] = value[PERIOD_W-1:0];
        REG_PERIOD_1:    period_ms[1] = value[PERIOD_W-1:0];
        REG_PERIOD_2:    period_ms[2] = value[PERIOD_W-1:0];
        REG_PERIOD_3:    period_ms[3] = value[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(in_item_t t);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] late;
      int                cmd;
      int                lim;
      res_item_t         r;
      if (!started) begin
        started     = 1'b1;
        start_ms    = t.now_ms;
        next_due_ms = t.now_ms;
      end
      if (t.rate_button) begin
        rate_sel       = RATE_W'((int'(rate_sel) + 1) % RATE_ENTRIES_DEF);
        next_due_ms    = t.now_ms;
        callback_fault = 1'b0;
        lag_fault      = 1'b0;
      end
      if (t.mode_button) begin
        mode_sel       = MODE_W'((int'(mode_sel) + 1) % MODE_COUNT);
        command_value  = '0;
        sweep_up       = 1'b1;
        next_due_ms    = t.now_ms;
        callback_fault = 1'b0;
        lag_fault      = 1'b0;
      end
      elapsed = t.now_ms - start_ms;
      if (elapsed > START_WINDOW_MS && t.callbacks_none) callback_fault = 1'b1;
      late = t.now_ms - next_due_ms;
      r.command_issued = 1'b0;
      if (!late[TIME_W-1]) begin
        r.command_issued = 1'b1;
        lag_fault = t.update_pending;
        lim = int'(max_command);
        if (mode_sel == MODE_FINE) begin
          cmd = sweep_up ? int'(command_value) + int'(fine_step)
                         : int'(command_value) - int'(fine_step);
        end else if (mode_sel == MODE_COARSE) begin
          cmd = sweep_up ? int'(command_value) + int'(coarse_step)
                         : int'(command_value) - int'(coarse_step);
        end else begin
          cmd = (int'(t.pot_level) * int'(POT_SCALE)) / POT_FULL - int'(POT_OFFSET);
        end
        if (cmd >= lim) begin
          cmd      = lim;
          sweep_up = 1'b0;
        end else if (cmd <= -lim) begin
          cmd      = -lim;
          sweep_up = 1'b1;
        end
        command_value = CMD_W'(cmd);
        next_due_ms   = t.now_ms + TIME_W'(period_ms[rate_sel]);
      end
      r.steer_command     = command_value;
      r.rate_index        = rate_sel;
      r.motion_mode       = mode_sel;
      r.no_callback_fault = callback_fault;
      r.lag_fault         = lag_fault;
      r.led_red           = callback_fault | ~t.driver_ready | lag_fault;
      awaited_status.push_back(r);
    endfunction

    function void check_status(res_item_t got);
      res_item_t want;
      bit        bad;
      if (awaited_status.size() == 0) begin
        failures++;
        if (failures <= 10) $display("status item %h arrived with nothing awaited", got);
        return;
      end
      want = awaited_status.pop_front();
      bad = (got.steer_command !== want.steer_command) ||
            (got.command_issued !== want.command_issued) ||
            (got.rate_index !== want.rate_index) ||
            (got.motion_mode !== want.motion_mode) ||
            (got.no_callback_fault !== want.no_callback_fault) ||
            (got.lag_fault !== want.lag_fault) ||
            (got.led_red !== want.led_red);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected cmd %0d iss %b rate %0d mode %0d ncb %b lag %b red %b",
                   want.steer_command, want.command_issued, want.rate_index,
                   want.motion_mode, want.no_callback_fault, want.lag_fault, want.led_red);
          $display("          actual   cmd %0d iss %b rate %0d mode %0d ncb %b lag %b red %b",
                   got.steer_command, got.command_issued, got.rate_index,
                   got.motion_mode, got.no_callback_fault, got.lag_fault, got.led_red);
        end
      end
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  stc_status_scoreboard sb = new();
  int send_calm    = 0;
  int recv_calm    = 0;
  int stall_cycles = 0;
  bit hold_request = 1'b0;
  bit hold_active  = 1'b0;

  servo_test_command_generator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(10, 30);
    return $urandom_range(0, 17);
  endfunction

  function automatic in_item_t tick_item(logic [31:0] now, logic rb, logic mb,
                                         logic [7:0] pot, logic cbn, logic pend, logic rdy);
    in_item_t t;
    t.now_ms         = now;
    t.rate_button    = rb;
    t.mode_button    = mb;
    t.pot_level      = pot;
    t.callbacks_none = cbn;
    t.update_pending = pend;
    t.driver_ready   = rdy;
    return t;
  endfunction

  task automatic send_tick(input in_item_t t);
    int gap;
    gap = draw_wait(send_calm);
    if (hold_active) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, t.driver_ready, t.update_pending, t.callbacks_none,
                  t.pot_level, t.mode_button, t.rate_button, t.now_ms};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    sb.set_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_status.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("servo_test_command_generator test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : status_sink
    int        gap;
    res_item_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_wait(recv_calm);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        gap          = LONG_HOLD;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hold_active = 1'b0;
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      got.steer_command     = out_tdata[10:0];
      got.command_issued    = out_tdata[11];
      got.rate_index        = out_tdata[13:12];
      got.motion_mode       = out_tdata[15:14];
      got.no_callback_fault = out_tdata[16];
      got.lag_fault         = out_tdata[17];
      got.led_red           = out_tdata[18];
      sb.check_status(got);
    end
  end

  initial begin : tick_source
    logic [31:0] clock_ms;
    logic [31:0] far_due;
    logic [7:0]  pot;
    int          cap;
    int          fine_v;
    int          coarse_v;
    int          max_v;
    int          per_v [4];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first tick fires at once; the timeline then crosses the wrap of the millisecond
    // counter while it steps through every mode, rate and fault case.
    send_tick(tick_item(DIR_START,          0, 0, 8'hFF, 1, 0, 1));
    send_tick(tick_item(DIR_START + 32'd1,  0, 0, 8'h00, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd20, 0, 0, 8'h00, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd45, 0, 0, 8'd128, 0, 1, 1));
    send_tick(tick_item(DIR_START + 32'd50, 0, 0, 8'd128, 0, 0, 0));
    send_tick(tick_item(DIR_START + 32'd52, 1, 0, 8'd128, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd60, 0, 1, 8'd7, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd70, 0, 0, 8'd7, 0, 1, 1));
    send_tick(tick_item(DIR_START + 32'd75, 1, 1, 8'd7, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd80, 0, 0, 8'd7, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd100, 0, 0, 8'd7, 1, 0, 1));
    send_tick(tick_item(DIR_START + 32'd101, 0, 0, 8'd7, 1, 0, 1));
    send_tick(tick_item(DIR_START + 32'd105, 0, 0, 8'd7, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd110, 0, 1, 8'hFF, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd120, 1, 0, 8'h00, 0, 0, 1));
    send_tick(tick_item(DIR_START + 32'd125, 1, 0, 8'h01, 0, 0, 1));
    far_due = DIR_START + 32'd145;
    send_tick(tick_item(far_due + 32'h8000_0000, 0, 0, 8'd254, 0, 0, 1));
    clock_ms = far_due + 32'h7FFF_FFFF;
    send_tick(tick_item(clock_ms, 0, 0, 8'd254, 0, 1, 1));
    clock_ms = clock_ms + 32'd20;
    send_tick(tick_item(clock_ms, 0, 0, 8'd254, 0, 0, 1));
    clock_ms = clock_ms + 32'd20;
    send_tick(tick_item(clock_ms, 0, 0, 8'd127, 0, 0, 1));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          fine_v = 1;
          coarse_v = 1;
          max_v = 1;
          for (int k = 0; k < 4; k++) per_v[k] = 1;
        end
        1: begin
          fine_v = 255;
          coarse_v = 255;
          max_v = 1000;
          for (int k = 0; k < 4; k++) per_v[k] = 1000;
        end
        default: begin
          fine_v   = $urandom_range(1, 255);
          coarse_v = $urandom_range(1, 255);
          max_v    = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 1000);
          for (int k = 0; k < 4; k++) begin
            per_v[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000)
                                                   : $urandom_range(1, 40);
          end
        end
      endcase
      cfg_write(REG_FINE_STEP, 32'(fine_v));
      cfg_write(REG_COARSE_STEP, 32'(coarse_v));
      cfg_write(REG_MAX_COMMAND, 32'(max_v));
      for (int k = 0; k < 4; k++) cfg_write(REG_IDX_W'(REG_PERIOD_0 + k), 32'(per_v[k]));
      if (phase == 2) begin
        cfg_write(REG_UNMAPPED, $urandom);
        hold_request = 1'b1;
      end

      // Time mostly runs forwards in steps scaled to the current period; now and then it
      // jumps to an arbitrary value, forwards or backwards.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cap = int'(sb.period_ms[sb.rate_sel]) / 2 + 2;
        if ($urandom_range(0, 11) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, cap);
        if ($urandom_range(0, 7) == 0) pot = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else pot = 8'($urandom_range(0, 255));
        send_tick(tick_item(clock_ms, $urandom_range(0, 11) == 0, $urandom_range(0, 9) == 0,
                            pot, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                            $urandom_range(0, 7) != 0));
      end
    end

    settle();
    if (sb.awaited_status.size() != 0) sb.failures++;
    if (sb.failures == 0) begin
      $display("servo_test_command_generator test passed");
    end else begin
      $display("servo_test_command_generator test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/stc_pkg.sv
rtl/core/stc_cfg.sv
rtl/core/stc_core.sv
rtl/core/servo_test_command_generator.sv
verif/servo_test_command_generator_tb.sv
